@@ rtl/svie_pkg.sv @@
`timescale 1ns / 1ps

package svie_pkg;

    localparam int STACK_BYTES = 65536;
    localparam int REG_COUNT   = 32;
    localparam int FRAME_DEPTH = 16;
    localparam int WORD_BYTES  = 4;

    localparam int SM_AW = $clog2(STACK_BYTES);
    localparam int RF_AW = $clog2(REG_COUNT);
    localparam int FS_AW = $clog2(FRAME_DEPTH);
    localparam int FD_W  = $clog2(FRAME_DEPTH + 1);

    localparam int IN_W  = 80;
    localparam int OUT_W = 88;

    typedef enum logic [4:0] {
        ACT_NOP    = 5'd0,
        ACT_PUSH   = 5'd1,
        ACT_POP    = 5'd2,
        ACT_ADD    = 5'd3,
        ACT_SUB    = 5'd4,
        ACT_MUL    = 5'd5,
        ACT_DIV    = 5'd6,
        ACT_MOV    = 5'd7,
        ACT_CALL   = 5'd8,
        ACT_CMP    = 5'd9,
        ACT_JMP    = 5'd10,
        ACT_JE     = 5'd11,
        ACT_JNE    = 5'd12,
        ACT_JLT    = 5'd13,
        ACT_JGT    = 5'd14,
        ACT_SETGT  = 5'd15,
        ACT_SETLT  = 5'd16,
        ACT_SETSP  = 5'd17,
        ACT_GETSP  = 5'd18,
        ACT_LDI    = 5'd19,
        ACT_RET    = 5'd20,
        ACT_HALT   = 5'd21
    } t_act;

    typedef enum logic [1:0] {
        KIND_REG   = 2'd0,
        KIND_ADDR  = 2'd1,
        KIND_LIT   = 2'd2,
        KIND_LABEL = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_OPERAND   = 3'd1,
        ERR_DIV_ZERO  = 3'd2,
        ERR_ADDR      = 3'd3,
        ERR_FRAME_OVF = 3'd4,
        ERR_FRAME_UNF = 3'd5
    } t_err;

    typedef struct packed {
        logic       clr;
        logic       load;
        logic       rd_right;
        logic       cap_a;
        logic       cap_b;
        logic       decide;
        logic       mem_rd;
        logic       div_start;
        logic       exec;
        logic       mem_wr;
        logic       out_load;
        logic [2:0] cnt;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic need_mrd;
        logic need_div;
        logic need_mwr;
        logic div_done;
        logic out_free;
    } t_sts;

    function automatic logic addr_ok(input logic signed [32:0] x);
        return (x >= 33'sd0) && (x <= $signed(33'(STACK_BYTES - WORD_BYTES)));
    endfunction

    function automatic logic reg_ok(input logic [31:0] v);
        return v < 32'(REG_COUNT);
    endfunction

endpackage

@@ rtl/svie_div.sv @@
`timescale 1ns / 1ps

module svie_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    import svie_pkg::*;

    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_sh;
    logic [32:0] w_diff;

    assign w_sh   = {r_rem, r_quo[31]};
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[32]) begin
                r_rem <= w_diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= w_sh[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ rtl/svie_ctl.sv @@
`timescale 1ns / 1ps

module svie_ctl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  svie_pkg::t_sts  i_sts,
    output svie_pkg::t_cmd  o_cmd
);
    import svie_pkg::*;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_RA,
        S_RB,
        S_CAPB,
        S_DEC,
        S_PLAN,
        S_MRD,
        S_DIV,
        S_DIVW,
        S_EXEC,
        S_MWR,
        S_DONE
    } t_state;

    t_state     r_state;
    logic [2:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_CLR:  if (i_sts.clr_done) r_state <= S_IDLE;
                S_IDLE: if (i_s_tvalid) r_state <= S_RA;
                S_RA:   r_state <= S_RB;
                S_RB:   r_state <= S_CAPB;
                S_CAPB: r_state <= S_DEC;
                S_DEC:  r_state <= S_PLAN;
                S_PLAN: begin
                    r_cnt <= '0;
                    priority if (i_sts.need_mrd) r_state <= S_MRD;
                    else if (i_sts.need_div) r_state <= S_DIV;
                    else r_state <= S_EXEC;
                end
                S_MRD: begin
                    if (r_cnt == 3'd4) begin
                        r_state <= S_EXEC;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_DIV:  r_state <= S_DIVW;
                S_DIVW: if (i_sts.div_done) r_state <= S_EXEC;
                S_EXEC: begin
                    r_cnt   <= '0;
                    r_state <= i_sts.need_mwr ? S_MWR : S_DONE;
                end
                S_MWR: begin
                    if (r_cnt == 3'd3) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_DONE: if (i_sts.out_free) r_state <= S_IDLE;
                default: r_state <= S_CLR;
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.cnt       = r_cnt;
        o_cmd.clr       = (r_state == S_CLR);
        o_cmd.load      = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.rd_right  = (r_state == S_RB);
        o_cmd.cap_a     = (r_state == S_RB);
        o_cmd.cap_b     = (r_state == S_CAPB);
        o_cmd.decide    = (r_state == S_DEC);
        o_cmd.mem_rd    = (r_state == S_MRD);
        o_cmd.div_start = (r_state == S_DIV);
        o_cmd.exec      = (r_state == S_EXEC);
        o_cmd.mem_wr    = (r_state == S_MWR);
        o_cmd.out_load  = (r_state == S_DONE) && i_sts.out_free;
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

@@ rtl/svie_dp.sv @@
`timescale 1ns / 1ps

module svie_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  svie_pkg::t_cmd              i_cmd,
    output svie_pkg::t_sts              o_sts,
    input  logic [svie_pkg::IN_W-1:0]   i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [svie_pkg::OUT_W-1:0]  o_m_tdata
);
    import svie_pkg::*;

    logic [4:0]  r_act;
    logic [1:0]  r_lk;
    logic [31:0] r_lv;
    logic [1:0]  r_rk;
    logic [31:0] r_rv;
    logic [31:0] r_a;
    logic [31:0] r_b;
    logic [31:0] r_sp;
    logic [31:0] r_fp;
    logic [2:0]  r_flags;
    logic [FD_W-1:0] r_depth;
    t_err        r_err;
    logic        r_need_mrd;
    logic        r_need_div;
    logic        r_need_mwr;
    logic [SM_AW-1:0] r_mra;
    logic [SM_AW-1:0] r_mwa;
    logic [31:0] r_mword;
    logic [31:0] r_wval;
    logic        r_jt;
    logic        r_ct;
    logic        r_rt;
    logic        r_hl;
    logic [15:0] r_tgt;
    logic        r_out_vld;
    logic [OUT_W-1:0] r_out;

    logic [31:0] r_rf [REG_COUNT];
    logic [REG_COUNT-1:0] r_rf_vld;
    logic [31:0] r_rf_q;
    logic        r_rf_qv;

    logic [7:0]  r_sm [STACK_BYTES];
    logic [7:0]  r_sm_q;
    logic [SM_AW-1:0] r_clr_idx;
    logic        r_clr_done;

    logic [63:0] r_fs_ptr [FRAME_DEPTH];
    logic [2:0]  r_fs_flg [FRAME_DEPTH];

    logic        lreg, laddr, llab, rreg, raddr, lok, rok;
    logic signed [32:0] lv33, rv33, sp33, fp33, a33, lvfp, rvfp, spm4;
    t_err        n_err;
    logic        n_mrd, n_mwr, n_div;
    logic signed [32:0] n_mra, n_mwa;
    logic [RF_AW-1:0] rd_idx;
    logic [31:0] rf_m;
    logic [1:0]  cap_idx;
    logic [FD_W-1:0] dm1;
    logic [31:0] abs_a, abs_b;
    logic        div_done;
    logic [31:0] div_q;
    logic [63:0] prod;
    logic [31:0] v;
    logic        we;
    logic        jcond;

    assign lreg  = (r_lk == KIND_REG);
    assign laddr = (r_lk == KIND_ADDR);
    assign llab  = (r_lk == KIND_LABEL);
    assign rreg  = (r_rk == KIND_REG);
    assign raddr = (r_rk == KIND_ADDR);
    assign lok   = reg_ok(r_lv);
    assign rok   = reg_ok(r_rv);
    assign lv33  = {r_lv[31], r_lv};
    assign rv33  = {r_rv[31], r_rv};
    assign sp33  = {r_sp[31], r_sp};
    assign fp33  = {r_fp[31], r_fp};
    assign a33   = {r_b[31], r_b};
    assign lvfp  = lv33 + fp33;
    assign rvfp  = rv33 + fp33;
    assign spm4  = sp33 - 33'sd4;
    assign dm1   = r_depth - FD_W'(1);

    always_comb begin
        n_err = ERR_OK;
        n_mrd = 1'b0;
        n_mwr = 1'b0;
        n_div = 1'b0;
        n_mra = lv33;
        n_mwa = sp33;
        unique case (r_act)
            ACT_PUSH: begin
                if (llab || (lreg && !lok)) n_err = ERR_OPERAND;
                else if ((laddr && !addr_ok(lv33)) || !addr_ok(sp33)) n_err = ERR_ADDR;
                n_mrd = laddr;
                n_mwr = 1'b1;
            end
            ACT_POP: begin
                if (r_lk[1] || (lreg && !lok)) n_err = ERR_OPERAND;
                else if (!addr_ok(spm4) || (laddr && !addr_ok(lv33))) n_err = ERR_ADDR;
                n_mrd = 1'b1;
                n_mwr = laddr;
                n_mra = spm4;
                n_mwa = lv33;
            end
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
                if (!lreg || !rreg || !lok || !rok) n_err = ERR_OPERAND;
                else if ((r_act == ACT_DIV) && (r_b == 32'd0)) n_err = ERR_DIV_ZERO;
                n_div = (r_act == ACT_DIV);
            end
            ACT_MOV: begin
                if ((rreg && !rok) || (lreg && !lok)) n_err = ERR_OPERAND;
                else if ((raddr && !addr_ok(rvfp)) || (laddr && !addr_ok(lvfp))) begin
                    n_err = ERR_ADDR;
                end
                n_mrd = raddr;
                n_mwr = laddr;
                n_mra = rvfp;
                n_mwa = lvfp;
            end
            ACT_CALL: begin
                if (llab && (r_depth == FD_W'(FRAME_DEPTH))) n_err = ERR_FRAME_OVF;
            end
            ACT_CMP: begin
                if (lreg && rreg && (!lok || !rok)) n_err = ERR_OPERAND;
            end
            ACT_SETGT, ACT_SETLT: begin
                if (!lreg || !lok) n_err = ERR_OPERAND;
            end
            ACT_SETSP, ACT_GETSP: begin
                if (lreg && !lok) n_err = ERR_OPERAND;
            end
            ACT_LDI: begin
                if (lreg && rreg) begin
                    if (!lok || !rok) n_err = ERR_OPERAND;
                    else if (!addr_ok(a33)) n_err = ERR_ADDR;
                    n_mrd = 1'b1;
                end
                n_mra = a33;
            end
            ACT_RET: begin
                if (r_depth == '0) n_err = ERR_FRAME_UNF;
            end
            default: ;
        endcase
    end

    assign abs_a = r_a[31] ? (32'd0 - r_a) : r_a;
    assign abs_b = r_b[31] ? (32'd0 - r_b) : r_b;

    svie_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (abs_a),
        .i_divisor  (abs_b),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign prod = 64'(r_a) * 64'(r_b);

    always_comb begin
        v  = '0;
        we = 1'b0;
        unique case (r_act)
            ACT_PUSH:  v = lreg ? r_a : (laddr ? r_mword : r_lv);
            ACT_POP:   begin v = r_mword; we = lreg; end
            ACT_ADD:   begin v = r_a + r_b; we = 1'b1; end
            ACT_SUB:   begin v = r_a - r_b; we = 1'b1; end
            ACT_MUL:   begin v = prod[31:0]; we = 1'b1; end
            ACT_DIV:   begin
                v  = (r_a[31] ^ r_b[31]) ? (32'd0 - div_q) : div_q;
                we = 1'b1;
            end
            ACT_MOV:   begin v = rreg ? r_b : (raddr ? r_mword : 32'd0); we = lreg; end
            ACT_SETGT: begin v = {31'd0, r_flags[2]}; we = 1'b1; end
            ACT_SETLT: begin v = {31'd0, r_flags[1]}; we = 1'b1; end
            ACT_GETSP: begin v = r_sp; we = lreg; end
            ACT_LDI:   begin v = r_mword; we = lreg && rreg; end
            default: ;
        endcase
    end

    always_comb begin
        unique case (r_act)
            ACT_JMP: jcond = 1'b1;
            ACT_JE:  jcond = r_flags[0];
            ACT_JNE: jcond = !r_flags[0];
            ACT_JLT: jcond = r_flags[1];
            ACT_JGT: jcond = r_flags[2];
            default: jcond = 1'b0;
        endcase
    end

    assign rd_idx  = i_cmd.rd_right ? r_rv[RF_AW-1:0] : r_lv[RF_AW-1:0];
    assign rf_m    = r_rf_qv ? r_rf_q : 32'd0;
    assign cap_idx = 2'(i_cmd.cnt - 3'd1);

    always_ff @(posedge i_clk) begin
        r_rf_q  <= r_rf[rd_idx];
        r_rf_qv <= r_rf_vld[rd_idx];
        if (i_cmd.exec && (r_err == ERR_OK) && we) begin
            r_rf[r_lv[RF_AW-1:0]] <= v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr && !r_clr_done) begin
            r_sm[r_clr_idx] <= 8'd0;
        end else if (i_cmd.mem_wr) begin
            r_sm[r_mwa + SM_AW'(i_cmd.cnt[1:0])] <= r_wval[8*i_cmd.cnt[1:0] +: 8];
        end
        r_sm_q <= r_sm[r_mra + SM_AW'(i_cmd.cnt[1:0])];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (r_err == ERR_OK) && (r_act == ACT_CALL) && llab) begin
            r_fs_ptr[r_depth[FS_AW-1:0]] <= {r_fp, r_sp};
            r_fs_flg[r_depth[FS_AW-1:0]] <= r_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_s_tdata[4:0];
            r_lk  <= i_s_tdata[6:5];
            r_lv  <= i_s_tdata[38:7];
            r_rk  <= i_s_tdata[40:39];
            r_rv  <= i_s_tdata[72:41];
        end
        if (i_cmd.cap_a) r_a <= rf_m;
        if (i_cmd.cap_b) r_b <= rf_m;
        if (i_cmd.decide) begin
            r_err      <= n_err;
            r_need_mrd <= n_mrd && (n_err == ERR_OK);
            r_need_div <= n_div && (n_err == ERR_OK);
            r_need_mwr <= n_mwr && (n_err == ERR_OK);
            r_mra      <= n_mra[SM_AW-1:0];
            r_mwa      <= n_mwa[SM_AW-1:0];
        end
        if (i_cmd.mem_rd && (i_cmd.cnt != 3'd0)) begin
            r_mword[8*cap_idx +: 8] <= r_sm_q;
        end
        if (i_cmd.exec) begin
            r_wval <= v;
            r_jt   <= (r_err == ERR_OK) && llab && jcond;
            r_ct   <= (r_err == ERR_OK) && llab && (r_act == ACT_CALL);
            r_rt   <= (r_err == ERR_OK) && (r_act == ACT_RET);
            r_hl   <= (r_act == ACT_HALT);
            r_tgt  <= ((r_err == ERR_OK) && llab &&
                       (jcond || (r_act == ACT_CALL))) ? r_lv[15:0] : 16'd0;
        end
        if (i_cmd.out_load) begin
            r_out <= {1'b0, r_fp, r_sp, r_err, r_tgt, r_hl, r_rt, r_ct, r_jt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp       <= '0;
            r_fp       <= '0;
            r_flags    <= '0;
            r_depth    <= '0;
            r_rf_vld   <= '0;
            r_clr_idx  <= '0;
            r_clr_done <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.clr && !r_clr_done) begin
                r_clr_idx <= r_clr_idx + SM_AW'(1);
                if (r_clr_idx == SM_AW'(STACK_BYTES - 1)) r_clr_done <= 1'b1;
            end
            if (i_cmd.exec && (r_err == ERR_OK)) begin
                if (we) r_rf_vld[r_lv[RF_AW-1:0]] <= 1'b1;
                unique case (r_act)
                    ACT_PUSH: r_sp <= r_sp + 32'd4;
                    ACT_POP:  r_sp <= r_sp - 32'd4;
                    ACT_CALL: begin
                        if (llab) begin
                            r_depth <= r_depth + FD_W'(1);
                            r_fp    <= r_sp;
                            r_flags <= '0;
                        end
                    end
                    ACT_CMP: begin
                        if (lreg && rreg) begin
                            if (r_a == r_b) r_flags <= 3'b001;
                            else if ($signed(r_a) < $signed(r_b)) r_flags <= 3'b010;
                            else r_flags <= 3'b100;
                        end
                    end
                    ACT_SETSP: if (lreg) r_sp <= r_a;
                    ACT_RET: begin
                        r_depth <= dm1;
                        r_sp    <= r_fs_ptr[dm1[FS_AW-1:0]][31:0];
                        r_fp    <= r_fs_ptr[dm1[FS_AW-1:0]][63:32];
                        r_flags <= r_fs_flg[dm1[FS_AW-1:0]];
                    end
                    default: ;
                endcase
            end
            if (i_cmd.out_load) r_out_vld <= 1'b1;
            else if (i_m_tready) r_out_vld <= 1'b0;
        end
    end

    always_comb begin
        o_sts.clr_done = r_clr_done;
        o_sts.need_mrd = r_need_mrd;
        o_sts.need_div = r_need_div;
        o_sts.need_mwr = r_need_mwr;
        o_sts.div_done = div_done;
        o_sts.out_free = !r_out_vld || i_m_tready;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;

endmodule

@@ rtl/stack_vm_instruction_executor.sv @@
`timescale 1ns / 1ps
// One request at a time: a new request is taken only once the previous result has gone to the output register.
// A word read from or written to the stack memory moves one byte per cycle.
// A divide runs in the radix-2 divider; the single register file read port sets the register read steps.
// After reset the stack memory is cleared one byte per cycle, all 65536 bytes, before a request is taken.
// Reset is synchronous and active low; it clears all control state, pointers, flags and frame depth.

module stack_vm_instruction_executor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // action, left_kind, left_value, right_kind, right_value
    input  logic [svie_pkg::IN_W-1:0]   i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // jump_taken, call_taken, return_taken, halted, target_index, error_code,
    // stack_pointer_out, frame_pointer_out
    output logic [svie_pkg::OUT_W-1:0]  o_m_tdata
);
    import svie_pkg::*;

    t_cmd cmd;
    t_sts sts;

    svie_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    svie_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

@@ rtl/svie_chk.sv @@
`timescale 1ns / 1ps

module svie_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_tvalid,
    input logic                        o_s_tready,
    input logic [svie_pkg::IN_W-1:0]   i_s_tdata,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [svie_pkg::OUT_W-1:0]  o_m_tdata
);
    import svie_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("Result request dropped or changed while stalled.");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[22:20] <= 3'(ERR_FRAME_UNF)))
        else $error("Error code out of range.");

    a_one_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> $onehot0(o_m_tdata[2:0]))
        else $error("More than one control transfer reported.");

    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[22:20] != 3'(ERR_OK)) |->
            (o_m_tdata[2:0] == 3'd0) && (o_m_tdata[19:4] == 16'd0))
        else $error("Failed request reports a taken transfer.");

    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("Second request taken while one is executing.");

endmodule

bind stack_vm_instruction_executor svie_chk u_svie_chk (.*);
